// ===== hw/rtl/gbd_pkg.sv =====
// ----------------------------------------------------------------------------
// gbd_pkg: shared types and constants for the signed Golomb bit decoder
// Decoder phase encoding and the divisor reset value.
// ----------------------------------------------------------------------------
`default_nettype none

package gbd_pkg;

  typedef enum logic [1:0] {
    PH_SIGN  = 2'd0,
    PH_UNARY = 2'd1,
    PH_REM   = 2'd2,
    PH_EXTRA = 2'd3
  } gbd_phase_t;

  localparam int unsigned DIVISOR_RESET = 3;

endpackage

`default_nettype wire

// ===== hw/rtl/gbd_in_if.sv =====
// ----------------------------------------------------------------------------
// gbd_in_if: code bit channel
// Valid/ready channel carrying one bit of the coded stream per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbd_in_if;
  logic valid;
  logic ready;
  logic code_bit;

  modport source (output valid, output code_bit, input ready);
  modport sink   (input valid, input code_bit, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gbd_out_if.sv =====
// ----------------------------------------------------------------------------
// gbd_out_if: decoded value channel
// Valid/ready channel carrying a signed decoded value and its overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbd_out_if #(
  parameter int MAG_BITS = 24
);
  logic                       valid;
  logic                       ready;
  logic signed [MAG_BITS:0]   value;
  logic                       overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink   (input valid, input value, input overflow, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gbd_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gbd_cfg_if: divisor write channel
// Valid/ready channel carrying the Golomb divisor write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbd_cfg_if #(
  parameter int DIVISOR_BITS = 16
);
  logic                    valid;
  logic                    ready;
  logic [DIVISOR_BITS-1:0] divisor;

  modport source (output valid, output divisor, input ready);
  modport sink   (input valid, input divisor, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/gbd_cfg.sv =====
// ----------------------------------------------------------------------------
// gbd_cfg: divisor register
// Holds the divisor m and the truncated-binary terms derived from it at
// write time: u = 2^k - m and the remainder length n.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_cfg
  import gbd_pkg::*;
#(
  parameter int DIVISOR_BITS = 16,
  parameter int BL_W         = $clog2(DIVISOR_BITS + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  gbd_cfg_if.sink                cfg_if,
  output logic [DIVISOR_BITS-1:0] div_m,
  output logic [DIVISOR_BITS-1:0] div_u,
  output logic [BL_W-1:0]         rem_len
);

  logic [DIVISOR_BITS-1:0] m_r, m_nxt;
  logic [DIVISOR_BITS-1:0] u_r, u_nxt;
  logic [BL_W-1:0]         n_r, n_nxt;
  logic [DIVISOR_BITS-1:0] src_m;

  // k = ceil(log2 m) = bit length of m-1
  function automatic logic [BL_W-1:0] calc_k(input logic [DIVISOR_BITS-1:0] m);
    logic [DIVISOR_BITS-1:0] mm;
    logic [BL_W-1:0]         k;
    mm = m - 1'b1;
    k  = '0;
    for (int i = 0; i < DIVISOR_BITS; i++) begin
      if (mm[i]) k = BL_W'(i + 1);
    end
    return k;
  endfunction

  always_comb begin
    logic [BL_W-1:0]         k;
    logic [DIVISOR_BITS:0]   pow;
    logic [DIVISOR_BITS:0]   diff;
    src_m = rst_n ? cfg_if.divisor : DIVISOR_BITS'(DIVISOR_RESET);
    k     = calc_k(src_m);
    pow   = '0;
    pow[k] = 1'b1;
    diff  = pow - {1'b0, src_m};
    u_nxt = diff[DIVISOR_BITS-1:0];
    n_nxt = (u_nxt == '0) ? k : k - 1'b1;
    m_nxt = src_m;
  end

  assign cfg_if.ready = 1'b1;

  // a zero write is dropped
  always_ff @(posedge clk) begin
    if (!rst_n || (cfg_if.valid && (cfg_if.divisor != '0))) begin
      m_r <= m_nxt;
      u_r <= u_nxt;
      n_r <= n_nxt;
    end
  end

  assign div_m   = m_r;
  assign div_u   = u_r;
  assign rem_len = n_r;

endmodule

`default_nettype wire

// ===== hw/rtl/gbd_dec.sv =====
// ----------------------------------------------------------------------------
// gbd_dec: bit-serial codeword decoder
// Input bit register, one-step decode of the codeword state, and the result
// register. One bit advances per cycle unless a finished value is blocked.
// ----------------------------------------------------------------------------
`default_nettype none

module gbd_dec
  import gbd_pkg::*;
#(
  parameter int MAG_BITS     = 24,
  parameter int DIVISOR_BITS = 16,
  parameter int BL_W         = $clog2(DIVISOR_BITS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  gbd_in_if.sink                  in_if,
  gbd_out_if.source               out_if,
  input  wire logic [DIVISOR_BITS-1:0] div_m,
  input  wire logic [DIVISOR_BITS-1:0] div_u,
  input  wire logic [BL_W-1:0]         rem_len
);

  localparam int SUM_W = ((MAG_BITS > DIVISOR_BITS) ? MAG_BITS : DIVISOR_BITS) + 1;
  localparam int FIN_W = ((MAG_BITS > DIVISOR_BITS + 1) ? MAG_BITS : DIVISOR_BITS + 1) + 1;

  // input register
  logic bit_r, bvld_r;
  // codeword state
  gbd_phase_t              phase_r, phase_nxt;
  logic                    neg_r, neg_nxt;
  logic [MAG_BITS-1:0]     mag_r, mag_nxt;
  logic [DIVISOR_BITS-1:0] rem_r, rem_nxt;
  logic [BL_W-1:0]         left_r, left_nxt;
  logic                    sat_r, sat_nxt;
  // result register
  logic                    ovld_r;
  logic signed [MAG_BITS:0] val_r;
  logic                    ovf_r;

  logic                    has_res;
  logic                    adv;
  logic [DIVISOR_BITS:0]   fin_rem;
  logic [SUM_W-1:0]        usum;
  logic [FIN_W-1:0]        fsum;
  logic [MAG_BITS-1:0]     fin_mag;
  logic                    fin_ovf;
  logic [MAG_BITS:0]       fin_val;
  logic [DIVISOR_BITS-1:0] rem_sh;
  logic [DIVISOR_BITS:0]   ext_v;

  always_comb begin
    phase_nxt = phase_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    left_nxt  = left_r;
    sat_nxt   = sat_r;
    has_res   = 1'b0;
    fin_rem   = '0;
    usum      = {{(SUM_W-MAG_BITS){1'b0}}, mag_r} + {{(SUM_W-DIVISOR_BITS){1'b0}}, div_m};
    rem_sh    = {rem_r[DIVISOR_BITS-2:0], bit_r};
    ext_v     = {rem_r, bit_r};
    unique case (phase_r)
      PH_SIGN: begin
        neg_nxt   = bit_r;
        mag_nxt   = '0;
        rem_nxt   = '0;
        sat_nxt   = 1'b0;
        phase_nxt = PH_UNARY;
      end
      PH_UNARY: begin
        if (bit_r) begin
          if (|usum[SUM_W-1:MAG_BITS]) begin
            mag_nxt = '1;
            sat_nxt = 1'b1;
          end else begin
            mag_nxt = usum[MAG_BITS-1:0];
          end
        end else begin
          rem_nxt = '0;
          if (rem_len == '0) begin
            has_res = 1'b1;
          end else begin
            left_nxt  = rem_len;
            phase_nxt = PH_REM;
          end
        end
      end
      PH_REM: begin
        rem_nxt = rem_sh;
        if (left_r > BL_W'(1)) begin
          left_nxt = left_r - 1'b1;
        end else begin
          left_nxt = '0;
          if ((div_u != '0) && (rem_sh >= div_u)) begin
            phase_nxt = PH_EXTRA;
          end else begin
            has_res = 1'b1;
            fin_rem = {1'b0, rem_sh};
          end
        end
      end
      PH_EXTRA: begin
        has_res = 1'b1;
        fin_rem = (ext_v >= {1'b0, div_u}) ? ext_v - {1'b0, div_u} : ext_v;
      end
      default: begin
        phase_nxt = PH_SIGN;
      end
    endcase
    if (has_res) begin
      phase_nxt = PH_SIGN;
      neg_nxt   = 1'b0;
      mag_nxt   = '0;
      rem_nxt   = '0;
      left_nxt  = '0;
      sat_nxt   = 1'b0;
    end
  end

  // completion: add remainder, saturate, apply sign
  always_comb begin
    fsum = {{(FIN_W-MAG_BITS){1'b0}}, mag_r} + {{(FIN_W-DIVISOR_BITS-1){1'b0}}, fin_rem};
    if (|fsum[FIN_W-1:MAG_BITS]) begin
      fin_mag = '1;
      fin_ovf = 1'b1;
    end else begin
      fin_mag = fsum[MAG_BITS-1:0];
      fin_ovf = sat_r;
    end
    fin_val = neg_r ? (~{1'b0, fin_mag} + 1'b1) : {1'b0, fin_mag};
  end

  assign adv         = bvld_r && (!has_res || !ovld_r || out_if.ready);
  assign in_if.ready = !bvld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvld_r <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      bvld_r <= 1'b1;
    end else if (adv) begin
      bvld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      bit_r <= in_if.code_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SIGN;
      neg_r   <= 1'b0;
      mag_r   <= '0;
      rem_r   <= '0;
      left_r  <= '0;
      sat_r   <= 1'b0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      neg_r   <= neg_nxt;
      mag_r   <= mag_nxt;
      rem_r   <= rem_nxt;
      left_r  <= left_nxt;
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (adv && has_res) begin
      ovld_r <= 1'b1;
    end else if (out_if.ready) begin
      ovld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && has_res) begin
      val_r <= signed'(fin_val);
      ovf_r <= fin_ovf;
    end
  end

  assign out_if.valid    = ovld_r;
  assign out_if.value    = val_r;
  assign out_if.overflow = ovf_r;

endmodule

`default_nettype wire

// ===== hw/rtl/signed_golomb_bit_decoder.sv =====
// ----------------------------------------------------------------------------
// signed_golomb_bit_decoder: sign-magnitude Golomb decoder, one bit per request
// Decodes sign bit, unary quotient and truncated-binary remainder into a
// saturated signed value.
// ----------------------------------------------------------------------------
//  channel   dir  payload                      width
//  in_if     in   code_bit                     1
//  out_if    out  value (signed), overflow     MAG_BITS+1, 1
//  cfg_if    in   divisor (zero write dropped) DIVISOR_BITS
//
//  One code bit per cycle while no result is blocked; the final bit of a
//  codeword passes through the input register and its decoded value is then
//  written to the result register.
//  A waiting result stalls only the bit that completes the next codeword.
//  Reset (rst_n low, synchronous) sets divisor to 3 and expects a sign bit.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_golomb_bit_decoder
  import gbd_pkg::*;
#(
  parameter int MAG_BITS     = 24,
  parameter int DIVISOR_BITS = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbd_in_if.sink     in_if,
  gbd_out_if.source  out_if,
  gbd_cfg_if.sink    cfg_if
);

  localparam int BL_W = $clog2(DIVISOR_BITS + 1);

  logic [DIVISOR_BITS-1:0] div_m;
  logic [DIVISOR_BITS-1:0] div_u;
  logic [BL_W-1:0]         rem_len;

  gbd_cfg #(
    .DIVISOR_BITS (DIVISOR_BITS),
    .BL_W         (BL_W)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_if  (cfg_if),
    .div_m   (div_m),
    .div_u   (div_u),
    .rem_len (rem_len)
  );

  gbd_dec #(
    .MAG_BITS     (MAG_BITS),
    .DIVISOR_BITS (DIVISOR_BITS),
    .BL_W         (BL_W)
  ) u_dec (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .out_if  (out_if),
    .div_m   (div_m),
    .div_u   (div_u),
    .rem_len (rem_len)
  );

endmodule

`default_nettype wire
